### sv/spq_pkg.sv
// shared constants, codes and types of the sorted priority queue
// used by spq_cell, sorted_priority_queue_core, spq_checker and the testbench; no dependencies
package spq_pkg;

  localparam int CAPACITY   = 16;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int VALUE_W    = 32;
  localparam int RANK_W     = 16;
  localparam int OCC_W      = 5;
  localparam int ST_W       = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [VALUE_W-1:0] value;
  } spq_entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic              shift_in;   // enqueue transfer into a queue that is not full
    logic              shift_out;  // dequeue transfer from a queue that is not empty
    spq_entry_t        new_entry;
    logic [CNT_W-1:0]  count;
  } spq_ctl_t;

endpackage

### sv/spq_cell.sv
// one slot of the sorted chain: holds an entry, compares it against a new rank
// and trades entries with its neighbors; depends on spq_pkg
module spq_cell (
  input  logic                              clk,
  input  spq_pkg::spq_ctl_t                 ctl,
  input  logic [spq_pkg::CNT_W-1:0]         cell_idx,
  input  spq_pkg::spq_entry_t               left_entry,
  input  logic                              left_bigger,
  input  spq_pkg::spq_entry_t               right_entry,
  output spq_pkg::spq_entry_t               entry,
  output logic                              bigger
);

  spq_pkg::spq_entry_t entry_r;
  spq_pkg::spq_entry_t entry_nxt;
  logic                occupied;
  logic                at_end;

  assign occupied = cell_idx < ctl.count;
  assign at_end   = cell_idx == ctl.count;
  // held rank strictly above the new one: this slot moves right
  assign bigger   = occupied && ($signed(entry_r.rank) > $signed(ctl.new_entry.rank));
  assign entry    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.shift_in && (bigger || at_end)) begin
      entry_nxt = left_bigger ? left_entry : ctl.new_entry;
    end else if (ctl.shift_out) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### sv/sorted_priority_queue_core.sv
// top level of the sorted priority queue: control, count and result register
// around a chain of spq_cell slots; depends on spq_pkg and spq_cell
//
// usage
//   input stream: in_tuser carries the command (enqueue or dequeue), in_tdata
//   the data value and the rank of the entry. a transfer is one command.
//   result stream: one transfer per command, with the dequeued value (-1 on an
//   empty queue, 0 for every enqueue), the status in out_tuser and the entry
//   count after the command.
//   entries are kept sorted, smallest rank at slot 0; equal ranks leave in
//   arrival order. an enqueue into a full queue is dropped with full status.
// timing
//   the result is registered and appears on out_* in the cycle after the
//   input transfer. one command per cycle is sustained while out_tready is
//   high: every slot does a single rank compare against its own entry and
//   moves by one place, so the chain update does not depend on the fill level.
// reset and stalls
//   rst_n (synchronous) empties the queue and drops a pending result.
//   a stalled receiver holds the result register; in_tready then stays low
//   until the result is taken, and it rises in the same cycle as out_tready.
module sorted_priority_queue_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [spq_pkg::IN_DATA_W-1:0]      in_tdata,   // item_value [31:0], item_rank [47:32]
  input  logic                               in_tuser,   // command [0]
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [spq_pkg::OUT_DATA_W-1:0]     out_tdata,  // out_value [31:0], occupancy [36:32], zero pad
  output logic [spq_pkg::ST_W-1:0]           out_tuser   // status [1:0]
);

  localparam int N = spq_pkg::CAPACITY;

  logic                              accept;
  logic                              is_enq;
  logic                              full;
  logic                              empty;
  logic [spq_pkg::CNT_W-1:0]         count_r;
  logic [spq_pkg::CNT_W-1:0]         count_nxt;
  logic                              out_tvalid_r;
  logic [spq_pkg::VALUE_W-1:0]       out_value_r;
  logic [spq_pkg::VALUE_W-1:0]       out_value_nxt;
  logic [spq_pkg::ST_W-1:0]          out_status_r;
  logic [spq_pkg::ST_W-1:0]          out_status_nxt;
  logic [spq_pkg::OCC_W-1:0]         out_occ_r;
  spq_pkg::spq_ctl_t                 ctl;
  spq_pkg::spq_entry_t               cell_entry  [N];
  logic                              cell_bigger [N];

  // result register parts the two sides; refill while it drains
  assign in_tready = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_enq    = in_tuser == spq_pkg::CMD_ENQ;
  assign full      = count_r == spq_pkg::CNT_W'(N);
  assign empty     = count_r == '0;

  // command broadcast to the chain
  assign ctl.shift_in        = accept && is_enq && !full;
  assign ctl.shift_out       = accept && !is_enq && !empty;
  assign ctl.new_entry.value = in_tdata[spq_pkg::VALUE_W-1:0];
  assign ctl.new_entry.rank  = in_tdata[spq_pkg::VALUE_W +: spq_pkg::RANK_W];
  assign ctl.count           = count_r;

  always_comb begin
    count_nxt      = count_r;
    out_value_nxt  = '0;
    out_status_nxt = spq_pkg::ST_OK;
    if (is_enq) begin
      if (full) begin
        out_status_nxt = spq_pkg::ST_FULL;
      end else begin
        count_nxt = count_r + spq_pkg::CNT_W'(1);
      end
    end else begin
      if (empty) begin
        out_status_nxt = spq_pkg::ST_EMPTY;
        out_value_nxt  = '1;
      end else begin
        // head of the queue always sits in slot 0
        out_value_nxt = cell_entry[0].value;
        count_nxt     = count_r - spq_pkg::CNT_W'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
      out_occ_r    <= spq_pkg::OCC_W'(count_nxt);
    end
  end

  // chain of slots, slot 0 at the front
  for (genvar i = 0; i < N; i++) begin : g_cell
    spq_pkg::spq_entry_t left_entry;
    logic                left_bigger;
    spq_pkg::spq_entry_t right_entry;

    if (i == 0) begin : g_first
      assign left_entry  = '0;
      assign left_bigger = 1'b0;
    end else begin : g_inner
      assign left_entry  = cell_entry[i-1];
      assign left_bigger = cell_bigger[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_body
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .cell_idx    (spq_pkg::CNT_W'(i)),
      .left_entry  (left_entry),
      .left_bigger (left_bigger),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .bigger      (cell_bigger[i])
    );
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(spq_pkg::OUT_DATA_W - spq_pkg::VALUE_W - spq_pkg::OCC_W){1'b0}},
                       out_occ_r, out_value_r};
  assign out_tuser  = out_status_r;

endmodule

### sv/spq_checker.sv
// port-level checks of sorted_priority_queue_core and the bind that attaches them
// depends on spq_pkg and on the port list of the top level
module spq_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [spq_pkg::OUT_DATA_W-1:0]     out_tdata,
  input logic [spq_pkg::ST_W-1:0]           out_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // every accepted command gives a result in the next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted command gave no result");

  // empty dequeue: value -1 and nothing held
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == spq_pkg::ST_EMPTY |->
      out_tdata[spq_pkg::VALUE_W-1:0] == '1 &&
      out_tdata[spq_pkg::VALUE_W +: spq_pkg::OCC_W] == '0)
    else $error("empty status with wrong value or count");

  // full rejection: value 0 and a full count
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == spq_pkg::ST_FULL |->
      out_tdata[spq_pkg::VALUE_W-1:0] == '0 &&
      out_tdata[spq_pkg::VALUE_W +: spq_pkg::OCC_W] ==
        spq_pkg::OCC_W'(spq_pkg::CAPACITY))
    else $error("full status with wrong value or count");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);

### verif/tb_sorted_priority_queue_core.sv
// self-checking testbench for sorted_priority_queue_core: directed and random
// enqueue/dequeue commands checked against a sorted-list prediction; depends on spq_pkg
module tb_sorted_priority_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  // quiet cycles (no transfer on either side) before the run is declared hung
  localparam int HANG_LIMIT   = 2000;
  // last items and results of the run go without any idling
  localparam int TAIL_ITEMS   = 250;
  // one long receiver hold-off once this many results have been taken
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 80;
  localparam int RANDOM_ITEMS = 1930;

  typedef struct {
    logic                        cmd;
    logic [spq_pkg::VALUE_W-1:0] value;
    logic [spq_pkg::RANK_W-1:0]  rank;
  } command_t;

  typedef struct {
    logic [spq_pkg::VALUE_W-1:0] value;
    logic [spq_pkg::ST_W-1:0]    status;
    logic [spq_pkg::OCC_W-1:0]   occupancy;
  } queue_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [spq_pkg::IN_DATA_W-1:0]  in_tdata  = '0;
  logic                           in_tuser  = spq_pkg::CMD_ENQ;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [spq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [spq_pkg::ST_W-1:0]       out_tuser;

  sorted_priority_queue_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // item_value [31:0], item_rank [47:32]
    .in_tuser   (in_tuser),   // command [0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // out_value [31:0], occupancy [36:32], zero pad
    .out_tuser  (out_tuser)   // status [1:0]
  );

  // commands still to be offered, and results still owed by the block
  command_t      pending_cmds[$];
  queue_result_t owed_results[$];

  // predicted queue contents, front entry at index 0
  logic [spq_pkg::VALUE_W-1:0]       held_value [spq_pkg::CAPACITY];
  logic signed [spq_pkg::RANK_W-1:0] held_rank  [spq_pkg::CAPACITY];
  int                                held_count = 0;

  int total_cmds    = 0;
  int results_taken = 0;
  int error_count   = 0;

  int in_gap    = 0;
  int out_stall = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // clock: 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic add_cmd(input logic cmd, input logic [spq_pkg::VALUE_W-1:0] value,
                         input logic [spq_pkg::RANK_W-1:0] rank);
    command_t c;
    c.cmd   = cmd;
    c.value = value;
    c.rank  = rank;
    pending_cmds.push_back(c);
  endtask

  // sorted insert behind equal ranks, front removal, full and empty handling
  task automatic predict_command(input logic cmd, input logic [spq_pkg::VALUE_W-1:0] value,
                                 input logic signed [spq_pkg::RANK_W-1:0] rank);
    queue_result_t r;
    int            pos;
    r.value  = '0;
    r.status = spq_pkg::ST_OK;
    if (cmd == spq_pkg::CMD_ENQ) begin
      if (held_count >= spq_pkg::CAPACITY) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_rank[pos] <= rank) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_value[i] = held_value[i-1];
          held_rank[i]  = held_rank[i-1];
        end
        held_value[pos] = value;
        held_rank[pos]  = rank;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = spq_pkg::ST_EMPTY;
        r.value  = '1;
      end else begin
        r.value = held_value[0];
        for (int i = 1; i < held_count; i++) begin
          held_value[i-1] = held_value[i];
          held_rank[i-1]  = held_rank[i];
        end
        held_count--;
      end
    end
    r.occupancy = held_count[spq_pkg::OCC_W-1:0];
    owed_results.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch on result %0d: %s expected 0x%08h got 0x%08h",
             results_taken, field, want, got);
    error_count++;
  endtask

  // stimulus: directed corner cases, then random commands in phases of
  // varying enqueue bias so the queue swings between empty and full
  initial begin
    int enq_pct;
    int rank_mode;
    logic [spq_pkg::VALUE_W-1:0] v;
    logic [spq_pkg::RANK_W-1:0]  rk;

    // dequeue from an empty queue
    add_cmd(spq_pkg::CMD_DEQ, 32'h1234_5678, 16'h5555);
    // value and rank extremes, ties at zero, at the top and at the bottom
    add_cmd(spq_pkg::CMD_ENQ, 32'h7fff_ffff, 16'h7fff);
    add_cmd(spq_pkg::CMD_ENQ, 32'h8000_0000, 16'h8000);
    add_cmd(spq_pkg::CMD_ENQ, 32'hffff_ffff, 16'h0000);
    add_cmd(spq_pkg::CMD_ENQ, 32'h0000_0000, 16'h0000);
    add_cmd(spq_pkg::CMD_ENQ, 32'h0000_0001, 16'h0000);
    add_cmd(spq_pkg::CMD_ENQ, 32'h0000_0002, 16'hffff);
    add_cmd(spq_pkg::CMD_ENQ, 32'h0000_0003, 16'h7fff);
    add_cmd(spq_pkg::CMD_ENQ, 32'h0000_0004, 16'h8000);
    add_cmd(spq_pkg::CMD_ENQ, 32'h0000_0005, 16'h0001);
    add_cmd(spq_pkg::CMD_ENQ, 32'haaaa_aaaa, 16'h5555);
    add_cmd(spq_pkg::CMD_ENQ, 32'h5555_5555, 16'haaaa);
    add_cmd(spq_pkg::CMD_ENQ, 32'h0000_0006, 16'hfffe);
    add_cmd(spq_pkg::CMD_ENQ, 32'h0000_0007, 16'h0000);
    add_cmd(spq_pkg::CMD_ENQ, 32'h0000_0008, 16'h7ffe);
    add_cmd(spq_pkg::CMD_ENQ, 32'h0000_0009, 16'h8001);
    add_cmd(spq_pkg::CMD_ENQ, 32'h0000_000a, 16'hffff);
    // queue now full: this enqueue is dropped
    add_cmd(spq_pkg::CMD_ENQ, 32'hdead_beef, 16'h8000);
    repeat (5) add_cmd(spq_pkg::CMD_DEQ, $urandom, 16'($urandom));

    enq_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 4))
          0: enq_pct = 15;
          1: enq_pct = 35;
          2: enq_pct = 50;
          3: enq_pct = 65;
          default: enq_pct = 85;
        endcase
      end
      rank_mode = $urandom_range(0, 9);
      if (rank_mode < 5) begin
        rk = 16'($urandom);
      end else if (rank_mode < 8) begin
        // narrow window around zero gives many ties
        rk = 16'($signed($urandom_range(0, 6)) - 3);
      end else begin
        case ($urandom_range(0, 3))
          0: rk = 16'h8000;
          1: rk = 16'h7fff;
          2: rk = 16'hffff;
          default: rk = 16'h0000;
        endcase
      end
      v = ($urandom_range(0, 19) == 0) ? ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff)
                                       : $urandom;
      add_cmd(($urandom_range(1, 100) <= enq_pct) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ,
              v, rk);
    end
    total_cmds = pending_cmds.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: offers the front of pending_cmds, predicts on each input transfer
  always @(posedge clk) begin : drive_input
    logic fire;
    bit   tail;
    fire = in_tvalid && in_tready;
    tail = pending_cmds.size() < TAIL_ITEMS;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        predict_command(in_tuser, in_tdata[spq_pkg::VALUE_W-1:0],
                        $signed(in_tdata[spq_pkg::VALUE_W+spq_pkg::RANK_W-1:spq_pkg::VALUE_W]));
        void'(pending_cmds.pop_front());
      end
      // a command on offer but not taken stays put
      if (!in_tvalid || fire) begin
        if (in_gap != 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!tail && (total_cmds - pending_cmds.size()) % 400 >= 150
                     && $urandom_range(0, 9) == 0) begin
          // idle burst of random length, this one included
          in_gap    <= $urandom_range(1, 14) - 1;
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata  <= {pending_cmds[0].rank, pending_cmds[0].value};
          in_tuser  <= pending_cmds[0].cmd;
        end
      end
    end
  end

  // receiver: random stall bursts, one long hold-off that backs up the input
  always @(posedge clk) begin : drive_ready
    bit tail;
    tail = results_taken >= total_cmds - TAIL_ITEMS;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && results_taken >= HOLD_AT) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (out_stall != 0) begin
      out_stall  <= out_stall - 1;
      out_tready <= 1'b0;
    end else if (!tail && results_taken % 300 < 200 && $urandom_range(0, 9) == 0) begin
      out_stall  <= $urandom_range(1, 14) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: each result transfer against the oldest owed result
  always @(posedge clk) begin : check_output
    queue_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected value", 32'h0, out_tdata[spq_pkg::VALUE_W-1:0]);
      end else begin
        want = owed_results.pop_front();
        if (out_tdata[spq_pkg::VALUE_W-1:0] !== want.value)
          report_mismatch("value", want.value, out_tdata[spq_pkg::VALUE_W-1:0]);
        if (out_tuser !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_tuser));
        if (out_tdata[spq_pkg::VALUE_W+spq_pkg::OCC_W-1:spq_pkg::VALUE_W] !== want.occupancy)
          report_mismatch("occupancy", 32'(want.occupancy),
                          32'(out_tdata[spq_pkg::VALUE_W+spq_pkg::OCC_W-1:spq_pkg::VALUE_W]));
      end
      results_taken <= results_taken + 1;
    end
  end

  // watchdog: too long without any transfer means the block is hung
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("hang: no transfer for %0d cycles, %0d results owed",
               quiet_cycles, owed_results.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // end of run: all commands taken, all results in, then a few spare cycles
  initial begin
    @(posedge rst_n);
    do @(posedge clk);
    while (pending_cmds.size() != 0 || owed_results.size() != 0);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
